/* design/top_k_inner_product_search_unit_macros.svh */
// ----------------------------------------------------------------------------
// top_k_inner_product_search_unit assertion macros
// shared concurrent assertion wrappers, clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef TOP_K_INNER_PRODUCT_SEARCH_UNIT_MACROS_SVH
`define TOP_K_INNER_PRODUCT_SEARCH_UNIT_MACROS_SVH

// checked only out of reset
`define TKIPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define TKIPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/tkips_pkg.sv */
// ----------------------------------------------------------------------------
// tkips_pkg
// types, codes and constants of the top-k inner product search unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkips_pkg;

  localparam int MAX_WORDS_DEF = 1024;
  localparam int MAX_DIMS_DEF  = 256;
  localparam int TOP_COUNT_DEF = 10;

  localparam int VAL_W       = 16;
  localparam int PROD_W      = 32;
  localparam int SCORE_W     = 40;
  localparam int IDX_W       = 10;
  localparam int RANK_W      = 4;
  localparam int ENTRY_W     = 10;
  localparam int COMP_W      = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 11;
  localparam int WORDS_REG_W = 11;
  localparam int DIMS_REG_W  = 9;

  localparam int WORDS_RESET = 1024;
  localparam int DIMS_RESET  = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_WORDS_IN_USE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE  = 4'd1;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_LOAD_TABLE = 2'd0,
    CMD_LOAD_QUERY = 2'd1,
    CMD_SEARCH     = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [ENTRY_W-1:0]       entry_index;
    logic [COMP_W-1:0]        component_index;
    logic signed [VAL_W-1:0]  component_value;
  } item_t;

  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic [IDX_W-1:0]          found_index;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } result_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  typedef struct packed {
    logic                      pipe_busy;
    logic signed [SCORE_W-1:0] score;
  } mac_stat_t;

endpackage

/* design/tkips_ram.sv */
// ----------------------------------------------------------------------------
// tkips_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkips_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tkips_mac.sv */
// ----------------------------------------------------------------------------
// tkips_mac
// shared multiply-accumulate unit: one product per cycle, saturated score
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkips_mac #(
  parameter int MAX_DIMS = tkips_pkg::MAX_DIMS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tkips_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [tkips_pkg::VAL_W-1:0]   table_i,
  input  logic signed [tkips_pkg::VAL_W-1:0]   query_i,
  output tkips_pkg::mac_stat_t                 stat_o
);

  localparam int SUM_W = tkips_pkg::PROD_W + $clog2(MAX_DIMS + 1) + 1;
  localparam int ACC_W = (SUM_W > tkips_pkg::SCORE_W + 1) ? SUM_W : tkips_pkg::SCORE_W + 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(tkips_pkg::SCORE_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(tkips_pkg::SCORE_MIN);

  logic                               rd_valid_q, prod_valid_q;
  logic signed [tkips_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]             acc_d, acc_q;

  assign prod_d = table_i * query_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_valid_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      // ram read data lands in the cycle after the issue
      rd_valid_q   <= ctrl_i.issue && !ctrl_i.clear;
      prod_valid_q <= rd_valid_q && !ctrl_i.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  always_comb begin
    stat_o.pipe_busy = rd_valid_q || prod_valid_q;
    if (acc_q > ACC_MAX) begin
      stat_o.score = tkips_pkg::SCORE_MAX;
    end else if (acc_q < ACC_MIN) begin
      stat_o.score = tkips_pkg::SCORE_MIN;
    end else begin
      stat_o.score = acc_q[tkips_pkg::SCORE_W-1:0];
    end
  end

endmodule

/* design/top_k_inner_product_search_unit.sv */
// ----------------------------------------------------------------------------
// top_k_inner_product_search_unit
// top-k maximum inner product search over a ram of fixed-point word vectors
// ----------------------------------------------------------------------------
// loads: one beat per cycle while not busy, busy stays low, no result
// search: each word runs through the single multiply-accumulate unit (issue,
//   drain), then into the best list by the one-step list compare (check, shift)
// then min(words, TOP_COUNT) result beats, one per cycle, one result each
// reset clears control and sets words/dims to their reset values; vector rams hold no reset
`timescale 1ns / 1ps

module top_k_inner_product_search_unit #(
  parameter int MAX_WORDS = tkips_pkg::MAX_WORDS_DEF,
  parameter int MAX_DIMS  = tkips_pkg::MAX_DIMS_DEF,
  parameter int TOP_COUNT = tkips_pkg::TOP_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  tkips_pkg::item_t                    item_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tkips_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tkips_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                                res_valid_o,
  output tkips_pkg::result_t                  res_o
);

  localparam int WCNT_W  = $clog2(MAX_WORDS + 1);
  localparam int DCNT_W  = $clog2(MAX_DIMS + 1);
  localparam int DADDR_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int TDEPTH  = MAX_WORDS * MAX_DIMS;
  localparam int TADDR_W = $clog2(TDEPTH);
  localparam int KW      = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int FW      = $clog2(TOP_COUNT + 1);
  localparam int WORDS_RST = (tkips_pkg::WORDS_RESET > MAX_WORDS) ?
                             MAX_WORDS : tkips_pkg::WORDS_RESET;
  localparam int DIMS_RST  = (tkips_pkg::DIMS_RESET > MAX_DIMS) ?
                             MAX_DIMS : tkips_pkg::DIMS_RESET;
  localparam int SW = tkips_pkg::SCORE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_CHECK,
    ST_SHIFT,
    ST_EMIT
  } state_e;

  state_e                 state_d, state_q;
  logic [WCNT_W-1:0]      words_d, words_q, w_d, w_q;
  logic [DCNT_W-1:0]      dims_d, dims_q, d_d, d_q;
  logic [TADDR_W-1:0]     addr_d, addr_q, base_d, base_q;
  logic [KW-1:0]          k_d, k_q;
  logic [FW-1:0]          filled_d, filled_q;
  logic                   res_valid_d, res_valid_q;
  tkips_pkg::result_t     res_d, res_q;
  logic signed [SW-1:0]   score_d, score_q;

  logic signed [SW-1:0]          best_score_q [TOP_COUNT];
  logic [tkips_pkg::IDX_W-1:0]   best_idx_q   [TOP_COUNT];
  logic                          best_we;
  logic signed [SW-1:0]          best_wscore;
  logic [tkips_pkg::IDX_W-1:0]   best_widx;
  logic [KW-1:0]                 rd_ptr;
  logic signed [SW-1:0]          best_rd_score;
  logic [tkips_pkg::IDX_W-1:0]   best_rd_idx;
  logic                          rd_less;

  logic                          accept;
  logic                          entry_ok, comp_ok;
  logic [31:0]                   tbl_lin, qry_lin, w_ext, wcfg, dcfg;
  logic                          tbl_we, qry_we;
  logic [tkips_pkg::VAL_W-1:0]   tbl_rdata, qry_rdata;
  tkips_pkg::mac_ctrl_t          mac_ctrl;
  tkips_pkg::mac_stat_t          mac_stat;
  logic                          word_done;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // load addressing, out-of-range beats are dropped
  assign entry_ok = 32'(item_i.entry_index) < 32'(MAX_WORDS);
  assign comp_ok  = 32'(item_i.component_index) < 32'(MAX_DIMS);
  assign tbl_lin  = 32'(item_i.entry_index) * 32'(MAX_DIMS) + 32'(item_i.component_index);
  assign qry_lin  = 32'(item_i.component_index);
  assign tbl_we   = accept && (item_i.cmd == tkips_pkg::CMD_LOAD_TABLE) && entry_ok && comp_ok;
  assign qry_we   = accept && (item_i.cmd == tkips_pkg::CMD_LOAD_QUERY) && comp_ok;

  tkips_ram #(
    .WIDTH (tkips_pkg::VAL_W),
    .DEPTH (TDEPTH)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_lin[TADDR_W-1:0]),
    .wdata_i (item_i.component_value),
    .raddr_i (addr_q),
    .rdata_o (tbl_rdata)
  );

  tkips_ram #(
    .WIDTH (tkips_pkg::VAL_W),
    .DEPTH (MAX_DIMS)
  ) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (qry_we),
    .waddr_i (qry_lin[DADDR_W-1:0]),
    .wdata_i (item_i.component_value),
    .raddr_i (d_q[DADDR_W-1:0]),
    .rdata_o (qry_rdata)
  );

  tkips_mac #(
    .MAX_DIMS (MAX_DIMS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .table_i ($signed(tbl_rdata)),
    .query_i ($signed(qry_rdata)),
    .stat_o  (mac_stat)
  );

  // single read port on the best list, shared by check, shift and emit
  always_comb begin
    unique case (state_q)
      ST_CHECK: rd_ptr = KW'(TOP_COUNT - 1);
      ST_SHIFT: rd_ptr = (k_q == '0) ? '0 : k_q - 1'b1;
      default:  rd_ptr = k_q;
    endcase
  end

  assign best_rd_score = best_score_q[rd_ptr];
  assign best_rd_idx   = best_idx_q[rd_ptr];
  assign rd_less       = best_rd_score < score_q;
  assign w_ext         = 32'(w_q);
  assign wcfg          = 32'(cfg_data_i[tkips_pkg::WORDS_REG_W-1:0]);
  assign dcfg          = 32'(cfg_data_i[tkips_pkg::DIMS_REG_W-1:0]);

  always_comb begin
    state_d     = state_q;
    words_d     = words_q;
    dims_d      = dims_q;
    w_d         = w_q;
    d_d         = d_q;
    addr_d      = addr_q;
    base_d      = base_q;
    k_d         = k_q;
    filled_d    = filled_q;
    score_d     = score_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mac_ctrl    = '0;
    best_we     = 1'b0;
    best_wscore = score_q;
    best_widx   = w_ext[tkips_pkg::IDX_W-1:0];
    word_done   = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tkips_pkg::CFG_WORDS_IN_USE: begin
          words_d = (wcfg > 32'(MAX_WORDS)) ? WCNT_W'(MAX_WORDS) : WCNT_W'(wcfg);
        end
        tkips_pkg::CFG_DIMS_IN_USE: begin
          dims_d = (dcfg > 32'(MAX_DIMS)) ? DCNT_W'(MAX_DIMS) : DCNT_W'(dcfg);
        end
        default: begin
        end
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.cmd == tkips_pkg::CMD_SEARCH) && (words_q != '0)) begin
          state_d        = ST_MAC;
          w_d            = '0;
          d_d            = '0;
          addr_d         = '0;
          base_d         = '0;
          filled_d       = '0;
          mac_ctrl.clear = 1'b1;
        end
      end
      ST_MAC: begin
        if (d_q != dims_q) begin
          mac_ctrl.issue = 1'b1;
          d_d            = d_q + 1'b1;
          addr_d         = addr_q + 1'b1;
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_stat.pipe_busy) begin
          score_d = mac_stat.score;
          if (filled_q == FW'(TOP_COUNT)) begin
            state_d = ST_CHECK;
            k_d     = KW'(TOP_COUNT - 1);
          end else begin
            state_d = ST_SHIFT;
            k_d     = filled_q[KW-1:0];
          end
        end
      end
      ST_CHECK: begin
        // full list: only a strictly better score goes in
        if (rd_less) begin
          state_d = ST_SHIFT;
        end else begin
          word_done = 1'b1;
        end
      end
      ST_SHIFT: begin
        if ((k_q != '0) && rd_less) begin
          best_we     = 1'b1;
          best_wscore = best_rd_score;
          best_widx   = best_rd_idx;
          k_d         = k_q - 1'b1;
        end else begin
          best_we   = 1'b1;
          word_done = 1'b1;
          if (filled_q != FW'(TOP_COUNT)) begin
            filled_d = filled_q + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        res_valid_d       = 1'b1;
        res_d.rank        = tkips_pkg::RANK_W'(k_q);
        res_d.found_index = best_rd_idx;
        res_d.score       = best_rd_score;
        res_d.last        = (32'(k_q) + 32'd1) == 32'(filled_q);
        if (res_d.last) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (word_done) begin
      if ((w_ext + 32'd1) == 32'(words_q)) begin
        state_d = ST_EMIT;
        k_d     = '0;
      end else begin
        state_d        = ST_MAC;
        w_d            = w_q + 1'b1;
        d_d            = '0;
        base_d         = base_q + TADDR_W'(MAX_DIMS);
        addr_d         = base_q + TADDR_W'(MAX_DIMS);
        mac_ctrl.clear = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      words_q     <= WCNT_W'(WORDS_RST);
      dims_q      <= DCNT_W'(DIMS_RST);
      w_q         <= '0;
      d_q         <= '0;
      addr_q      <= '0;
      base_q      <= '0;
      k_q         <= '0;
      filled_q    <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      words_q     <= words_d;
      dims_q      <= dims_d;
      w_q         <= w_d;
      d_q         <= d_d;
      addr_q      <= addr_d;
      base_q      <= base_d;
      k_q         <= k_d;
      filled_q    <= filled_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    if (best_we) begin
      best_score_q[k_q] <= best_wscore;
      best_idx_q[k_q]   <= best_widx;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`include "top_k_inner_product_search_unit_macros.svh"

  `TKIPS_ASSERT(a_res_from_emit, res_valid_o |-> $past(state_q == ST_EMIT), "result beat outside emit")
  `TKIPS_ASSERT(a_last_ends_run, (res_valid_o && res_o.last) |=> !res_valid_o, "beat after last")
  `TKIPS_ASSERT(a_busy_on_search, $rose(busy) |-> $past(start && (item_i.cmd == tkips_pkg::CMD_SEARCH)), "busy without search")
  `TKIPS_ASSERT(a_slot_in_list, (state_q == ST_SHIFT) |-> (32'(k_q) <= 32'(filled_q)), "insert slot past fill")
  `TKIPS_ASSERT_ALWAYS(a_fill_bound, !rst_ni || (filled_q <= FW'(TOP_COUNT)), "best list overfilled")

endmodule
